// File: rtl/core/tick_task_scheduler_macros.svh
// Assertion macros for the tick task scheduler.
`ifndef TICK_TASK_SCHEDULER_MACROS_SVH
`define TICK_TASK_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define TTS_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tick task scheduler check failed");
`define TTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tick task scheduler check failed");
`else
`define TTS_ASSERT(label, ante, cons)
`define TTS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/tts_pkg.sv
// Types and constants of the tick task scheduler.
package tts_pkg;

  localparam int TTS_SLOT_COUNT  = 8;
  localparam int TTS_MAX_RESULTS = 8;
  localparam int TTS_SERVED_W    = $clog2(TTS_MAX_RESULTS + 1);

  localparam int CMD_W    = 2;
  localparam int HANDLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int RUNS_W   = 8;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_DISPATCH = 2'd2,
    CMD_DELETE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 3'd0,
    STAT_RUN   = 3'd1,
    STAT_FULL  = 3'd2,
    STAT_EMPTY = 3'd3,
    STAT_NONE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } sched_state_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   delay;
    logic [TIME_W-1:0]   period;
    logic [RUNS_W-1:0]   runs;
  } slot_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot;
  } result_t;

endpackage

// File: rtl/core/tick_task_scheduler.sv
// Tick task scheduler: slot table in one memory, walked one slot per cycle.
//
//  channel  signals                                                  handshake
//  in       command task_handle start_delay repeat_period slot_to_delete  in_valid / in_stall
//  out      status run_handle slot_index last_result              out_valid / out_stall
//
// Add and delete: result held, then registered out when output is free; in_stall until then.
// Tick and dispatch: one slot a cycle, but for the out_stall pause below, through the single
// read port of the slot memory; dispatch ends early once eight slots are served.
// Reset clears the per-slot valid and occupied flags directly, with no sweep of the memory.
// A dispatch result waits in a hold stage; out_stall pauses the walk on the next slot to serve.
module tick_task_scheduler #(
  parameter int SLOT_COUNT = tts_pkg::TTS_SLOT_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tts_pkg::CMD_W-1:0]     command,
  input  logic [tts_pkg::HANDLE_W-1:0]  task_handle,
  input  logic [tts_pkg::TIME_W-1:0]    start_delay,
  input  logic [tts_pkg::TIME_W-1:0]    repeat_period,
  input  logic [tts_pkg::SLOT_W-1:0]    slot_to_delete,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tts_pkg::STATUS_W-1:0]  status,
  output logic [tts_pkg::HANDLE_W-1:0]  run_handle,
  output logic [tts_pkg::SLOT_W-1:0]    slot_index,
  output logic                          last_result
);
  import tts_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);
  localparam logic [TTS_SERVED_W-1:0] LAST_SERVED = TTS_SERVED_W'(TTS_MAX_RESULTS - 1);

  sched_state_t state, state_next;
  cmd_t         in_cmd, walk_cmd;
  logic [IW-1:0] p_idx;
  logic [SLOT_COUNT-1:0] occ, ent_valid;
  logic [TTS_SERVED_W-1:0] n_served;

  slot_t mem [SLOT_COUNT];
  slot_t rdata, wr_data, ent, tick_ent, disp_ent;
  logic [IW-1:0] rd_addr, wr_addr;
  logic wr_en;

  logic hold_valid;
  result_t hold, out_res;
  logic out_last, load_out, out_free, in_accept;

  logic free_found;
  logic [IW-1:0] free_idx, del_idx;
  logic del_hit, disp_hit, free_it, walk_stall, walk_done;

  assign in_cmd    = cmd_t'(command);
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!occ[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  assign del_idx = IW'(slot_to_delete);
  assign del_hit = (32'(slot_to_delete) < SLOT_COUNT) && occ[del_idx];

  // slot as stored; never-written or freed entries read as cleared
  assign ent = ent_valid[p_idx] ? rdata : '0;

  always_comb begin
    tick_ent = ent;
    if (ent.delay == '0) begin
      if (ent.runs != '1) tick_ent.runs = ent.runs + RUNS_W'(1);
      if (ent.period != '0) tick_ent.delay = ent.period;
    end else begin
      tick_ent.delay = ent.delay - TIME_W'(1);
    end
  end

  always_comb begin
    disp_ent      = ent;
    disp_ent.runs = ent.runs - RUNS_W'(1);
  end

  assign disp_hit   = (walk_cmd == CMD_DISPATCH) && (ent.runs != '0);
  assign free_it    = (ent.period == '0);
  assign walk_stall = disp_hit && hold_valid && !out_free;
  assign walk_done  = !walk_stall
                      && ((p_idx == LAST_IDX) || (disp_hit && (n_served == LAST_SERVED)));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_cmd == CMD_TICK || in_cmd == CMD_DISPATCH) state_next = ST_WALK;
          else state_next = ST_FLUSH;
        end
      end
      ST_WALK: begin
        if (walk_done) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = p_idx;
    wr_data  = tick_ent;
    load_out = 1'b0;
    out_res  = hold;
    out_last = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && in_cmd == CMD_ADD && free_found) begin
          wr_en   = 1'b1;
          wr_addr = free_idx;
          wr_data = '{handle: task_handle, delay: start_delay,
                      period: repeat_period, runs: '0};
        end
      end
      ST_WALK: begin
        rd_addr = (walk_stall || p_idx == LAST_IDX) ? p_idx : p_idx + IW'(1);
        if (walk_cmd == CMD_TICK) begin
          wr_en = occ[p_idx];
        end else begin
          wr_en    = disp_hit && !walk_stall && !free_it;
          wr_data  = disp_ent;
          load_out = disp_hit && !walk_stall && hold_valid;
        end
      end
      ST_FLUSH: begin
        load_out = out_free;
        out_last = 1'b1;
        if (!hold_valid) out_res = '{status: STAT_NONE, handle: '0, slot: '0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      occ        <= '0;
      ent_valid  <= '0;
      hold_valid <= 1'b0;
      n_served   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            n_served <= '0;
            unique case (in_cmd)
              CMD_ADD: begin
                hold_valid <= 1'b1;
                if (free_found) begin
                  occ[free_idx]       <= (task_handle != '0);
                  ent_valid[free_idx] <= 1'b1;
                end
              end
              CMD_DELETE: begin
                hold_valid <= 1'b1;
                if (del_hit) begin
                  occ[del_idx]       <= 1'b0;
                  ent_valid[del_idx] <= 1'b0;
                end
              end
              CMD_TICK:     hold_valid <= 1'b1;
              CMD_DISPATCH: hold_valid <= 1'b0;
            endcase
          end
        end
        ST_WALK: begin
          if (disp_hit && !walk_stall) begin
            hold_valid <= 1'b1;
            n_served   <= n_served + TTS_SERVED_W'(1);
            if (free_it) begin
              occ[p_idx]       <= 1'b0;
              ent_valid[p_idx] <= 1'b0;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) hold_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_accept) begin
      walk_cmd <= in_cmd;
      p_idx    <= '0;
      unique case (in_cmd)
        CMD_ADD: begin
          if (free_found) hold <= '{status: STAT_DONE, handle: '0, slot: SLOT_W'(free_idx)};
          else hold <= '{status: STAT_FULL, handle: '0, slot: '0};
        end
        CMD_DELETE: begin
          hold <= '{status: del_hit ? STAT_DONE : STAT_EMPTY, handle: '0,
                    slot: slot_to_delete};
        end
        CMD_TICK:     hold <= '{status: STAT_DONE, handle: '0, slot: '0};
        CMD_DISPATCH: hold <= '{status: STAT_NONE, handle: '0, slot: '0};
      endcase
    end else if (state == ST_WALK && !walk_stall) begin
      p_idx <= p_idx + IW'(1);
      if (disp_hit) hold <= '{status: STAT_RUN, handle: ent.handle, slot: SLOT_W'(p_idx)};
    end
    if (load_out) begin
      status      <= out_res.status;
      run_handle  <= out_res.handle;
      slot_index  <= out_res.slot;
      last_result <= out_last;
    end
  end

`include "tick_task_scheduler_macros.svh"

  `TTS_ASSERT_NEXT(a_stall_holds_slot, state == ST_WALK && walk_stall, state == ST_WALK && $stable(p_idx))
  `TTS_ASSERT_NEXT(a_add_to_flush, in_accept && in_cmd == CMD_ADD, state == ST_FLUSH)
  `TTS_ASSERT(a_served_bound, 1'b1, n_served <= TTS_SERVED_W'(TTS_MAX_RESULTS))
  `TTS_ASSERT(a_occ_implies_valid, 1'b1, (occ & ~ent_valid) == '0)
  `TTS_ASSERT(a_load_when_free, load_out, out_free)

endmodule

// File: bench/tb_tick_task_scheduler.sv
// Testbench for the tick task scheduler: directed table, then random commands against a predictor.
`timescale 1ns / 100ps

module tb_tick_task_scheduler;
  import tts_pkg::*;

  localparam int LIMIT = 1000000;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot;
    logic                last;
  } beat_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   delay;
    logic [TIME_W-1:0]   period;
    logic [SLOT_W-1:0]   slot;
    logic                typed;
    beat_t               typed_beat;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    command = '0;
  logic [HANDLE_W-1:0] task_handle = '0;
  logic [TIME_W-1:0]   start_delay = '0;
  logic [TIME_W-1:0]   repeat_period = '0;
  logic [SLOT_W-1:0]   slot_to_delete = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] run_handle;
  logic [SLOT_W-1:0]   slot_index;
  logic                last_result;

  logic [HANDLE_W-1:0] tbl_handle [TTS_SLOT_COUNT];
  logic [TIME_W-1:0]   tbl_delay  [TTS_SLOT_COUNT];
  logic [TIME_W-1:0]   tbl_period [TTS_SLOT_COUNT];
  logic [RUNS_W-1:0]   tbl_runs   [TTS_SLOT_COUNT];

  beat_t       awaited [$];
  beat_t       want_beat;
  script_row_t script [$];
  int          errors = 0;
  int          beat_no = 0;
  int          cycles = 0;
  int          stall_left = 0;
  int          stall_roll;
  bit          calm = 1'b0;

  tick_task_scheduler uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .task_handle    (task_handle),
    .start_delay    (start_delay),
    .repeat_period  (repeat_period),
    .slot_to_delete (slot_to_delete),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .run_handle     (run_handle),
    .slot_index     (slot_index),
    .last_result    (last_result)
  );

  always #1 clk = ~clk;

  function automatic beat_t mk_beat(status_t st, logic [HANDLE_W-1:0] h,
                                    logic [SLOT_W-1:0] s, logic l);
    beat_t b;
    b.status = st;
    b.handle = h;
    b.slot   = s;
    b.last   = l;
    return b;
  endfunction

  function automatic script_row_t script_row(cmd_t c, logic [HANDLE_W-1:0] h,
                                             logic [TIME_W-1:0] d, logic [TIME_W-1:0] p,
                                             logic [SLOT_W-1:0] s, logic typed,
                                             status_t st, logic [SLOT_W-1:0] ws);
    script_row_t r;
    r.cmd        = c;
    r.handle     = h;
    r.delay      = d;
    r.period     = p;
    r.slot       = s;
    r.typed      = typed;
    r.typed_beat = mk_beat(st, '0, ws, 1'b1);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < 50) $display("tb_tick_task_scheduler: mismatch: %s", what);
    errors++;
  endtask

  task automatic free_slot(input int i);
    tbl_handle[i] = '0;
    tbl_delay[i]  = '0;
    tbl_period[i] = '0;
    tbl_runs[i]   = '0;
  endtask

  // Updates the slot table for one command and queues the beats it produces.
  task automatic schedule_outcome(input cmd_t c, input logic [HANDLE_W-1:0] h,
                                  input logic [TIME_W-1:0] d, input logic [TIME_W-1:0] p,
                                  input logic [SLOT_W-1:0] s);
    int    i;
    int    found;
    int    served;
    beat_t batch [TTS_MAX_RESULTS];
    case (c)
      CMD_ADD: begin
        found = -1;
        for (i = 0; i < TTS_SLOT_COUNT; i++)
          if (found < 0 && tbl_handle[i] == '0) found = i;
        if (found < 0) begin
          awaited.push_back(mk_beat(STAT_FULL, '0, '0, 1'b1));
        end else begin
          tbl_handle[found] = h;
          tbl_delay[found]  = d;
          tbl_period[found] = p;
          tbl_runs[found]   = '0;
          awaited.push_back(mk_beat(STAT_DONE, '0, found[SLOT_W-1:0], 1'b1));
        end
      end
      CMD_TICK: begin
        for (i = 0; i < TTS_SLOT_COUNT; i++) begin
          if (tbl_handle[i] != '0) begin
            if (tbl_delay[i] == '0) begin
              if (tbl_runs[i] != '1) tbl_runs[i]++;
              if (tbl_period[i] != '0) tbl_delay[i] = tbl_period[i];
            end else begin
              tbl_delay[i]--;
            end
          end
        end
        awaited.push_back(mk_beat(STAT_DONE, '0, '0, 1'b1));
      end
      CMD_DISPATCH: begin
        served = 0;
        for (i = 0; i < TTS_SLOT_COUNT && served < TTS_MAX_RESULTS; i++) begin
          if (tbl_runs[i] != '0) begin
            batch[served] = mk_beat(STAT_RUN, tbl_handle[i], i[SLOT_W-1:0], 1'b0);
            served++;
            tbl_runs[i]--;
            if (tbl_period[i] == '0) free_slot(i);
          end
        end
        if (served == 0) begin
          awaited.push_back(mk_beat(STAT_NONE, '0, '0, 1'b1));
        end else begin
          batch[served-1].last = 1'b1;
          for (i = 0; i < served; i++) awaited.push_back(batch[i]);
        end
      end
      default: begin
        if (int'(s) >= TTS_SLOT_COUNT || tbl_handle[s] == '0) begin
          awaited.push_back(mk_beat(STAT_EMPTY, '0, s, 1'b1));
        end else begin
          free_slot(int'(s));
          awaited.push_back(mk_beat(STAT_DONE, '0, s, 1'b1));
        end
      end
    endcase
  endtask

  task automatic send_cmd(input cmd_t c, input logic [HANDLE_W-1:0] h,
                          input logic [TIME_W-1:0] d, input logic [TIME_W-1:0] p,
                          input logic [SLOT_W-1:0] s, input logic typed, input beat_t tb);
    in_valid       <= 1'b1;
    command        <= c;
    task_handle    <= h;
    start_delay    <= d;
    repeat_period  <= p;
    slot_to_delete <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    schedule_outcome(c, h, d, p, s);
    if (typed) begin
      void'(awaited.pop_back());
      awaited.push_back(tb);
    end
  endtask

  task automatic pace();
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    gap = 0;
    if (!calm) begin
      if (roll >= 90) gap = $urandom_range(8, 40);
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %0d/%h/%0d/%0b",
                                  status, run_handle, slot_index, last_result));
      end else begin
        want_beat = awaited.pop_front();
        if (status !== want_beat.status || run_handle !== want_beat.handle ||
            slot_index !== want_beat.slot || last_result !== want_beat.last)
          report_mismatch($sformatf("beat %0d got %0d/%h/%0d/%0b want %0d/%h/%0d/%0b",
                                    beat_no, status, run_handle, slot_index, last_result,
                                    want_beat.status, want_beat.handle, want_beat.slot,
                                    want_beat.last));
        beat_no++;
      end
    end
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        out_stall <= 1'b0;
      end else if (stall_roll < 95) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb_tick_task_scheduler: errors");
      $finish;
    end
  end

  initial begin
    int                  n;
    int                  k;
    int                  r;
    int                  q;
    int                  pick;
    cmd_t                c;
    logic [HANDLE_W-1:0] h;
    logic [TIME_W-1:0]   d;
    logic [TIME_W-1:0]   p;
    logic [SLOT_W-1:0]   s;
    beat_t               idle_beat;

    idle_beat = mk_beat(STAT_DONE, '0, '0, 1'b0);
    for (n = 0; n < TTS_SLOT_COUNT; n++) free_slot(n);

    script.push_back(script_row(CMD_DISPATCH, '0, '0, '0, '0, 1, STAT_NONE, 0));
    script.push_back(script_row(CMD_DELETE, '1, '1, '1, 7, 1, STAT_EMPTY, 7));
    script.push_back(script_row(CMD_TICK, '0, '0, '0, '0, 1, STAT_DONE, 0));
    script.push_back(script_row(CMD_ADD, 16'hffff, '0, '0, '0, 1, STAT_DONE, 0));
    // zero handle leaves the slot free for the next add
    script.push_back(script_row(CMD_ADD, '0, '1, '1, '1, 1, STAT_DONE, 1));
    script.push_back(script_row(CMD_ADD, 16'h0001, '1, '1, '0, 1, STAT_DONE, 1));
    script.push_back(script_row(CMD_ADD, 16'h1234, 1, 2, '0, 1, STAT_DONE, 2));
    script.push_back(script_row(CMD_ADD, 16'h8000, 0, 1, '0, 1, STAT_DONE, 3));
    script.push_back(script_row(CMD_ADD, 16'h00ff, 2, 0, '0, 1, STAT_DONE, 4));
    script.push_back(script_row(CMD_ADD, 16'ha5a5, 0, 3, '0, 1, STAT_DONE, 5));
    script.push_back(script_row(CMD_ADD, 16'h5a5a, 3, '1, '0, 1, STAT_DONE, 6));
    script.push_back(script_row(CMD_ADD, 16'h7fff, 0, 1, '0, 1, STAT_DONE, 7));
    script.push_back(script_row(CMD_ADD, 16'h4321, 5, 5, '0, 1, STAT_FULL, 0));
    script.push_back(script_row(CMD_TICK, '1, '1, '1, '1, 0, STAT_DONE, 0));
    script.push_back(script_row(CMD_DISPATCH, '1, '1, '1, '1, 0, STAT_DONE, 0));
    script.push_back(script_row(CMD_TICK, '0, '0, '0, '0, 0, STAT_DONE, 0));
    script.push_back(script_row(CMD_TICK, '0, '0, '0, '0, 0, STAT_DONE, 0));
    script.push_back(script_row(CMD_DISPATCH, '0, '0, '0, '0, 0, STAT_DONE, 0));
    script.push_back(script_row(CMD_DELETE, '0, '0, '0, 1, 1, STAT_DONE, 1));
    script.push_back(script_row(CMD_DELETE, '0, '0, '0, 1, 1, STAT_EMPTY, 1));
    script.push_back(script_row(CMD_DELETE, '0, '0, '0, 0, 0, STAT_DONE, 0));
    script.push_back(script_row(CMD_ADD, 16'h4242, 0, 5, '0, 0, STAT_DONE, 0));
    script.push_back(script_row(CMD_TICK, '0, '0, '0, '0, 0, STAT_DONE, 0));
    script.push_back(script_row(CMD_DISPATCH, '0, '0, '0, '0, 0, STAT_DONE, 0));
    script.push_back(script_row(CMD_DELETE, '0, '0, '0, 3, 0, STAT_DONE, 0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      send_cmd(script[i].cmd, script[i].handle, script[i].delay, script[i].period,
               script[i].slot, script[i].typed, script[i].typed_beat);
      pace();
    end
    drain_results();

    for (n = 0; n < 30; n++) begin
      calm = (n >= 10 && n < 18);
      if (n == 20) drain_results();
      r = $urandom_range(0, 99);
      h = HANDLE_W'($urandom);
      d = $urandom;
      p = $urandom;
      s = SLOT_W'($urandom);
      if (r < 28) begin
        c = CMD_ADD;
        q = $urandom_range(0, 99);
        if (q < 5) h = '0;
        else h = HANDLE_W'($urandom_range(1, 65535));
        q = $urandom_range(0, 99);
        if (q < 70) d = $urandom_range(0, 4);
        else if (q < 90) d = $urandom_range(0, 40);
        q = $urandom_range(0, 99);
        if (q < 30) p = '0;
        else if (q < 80) p = $urandom_range(1, 6);
      end else if (r < 60) begin
        c = CMD_TICK;
      end else if (r < 85) begin
        c = CMD_DISPATCH;
      end else begin
        c = CMD_DELETE;
        if ($urandom_range(0, 99) < 70) begin
          pick = -1;
          for (k = 0; k < TTS_SLOT_COUNT; k++)
            if (pick < 0 && tbl_handle[(int'(s) + k) % TTS_SLOT_COUNT] != '0)
              pick = (int'(s) + k) % TTS_SLOT_COUNT;
          if (pick >= 0) s = pick[SLOT_W-1:0];
        end
      end
      send_cmd(c, h, d, p, s, 1'b0, idle_beat);
      pace();
    end
    calm = 1'b0;

    // free slot 0, give it a one-shot task due at once, tick until its run count saturates
    drain_results();
    send_cmd(CMD_DELETE, HANDLE_W'($urandom), $urandom, $urandom, '0, 1'b0, idle_beat);
    pace();
    h = HANDLE_W'($urandom_range(1, 65535));
    send_cmd(CMD_ADD, h, '0, '0, SLOT_W'($urandom), 1'b0, idle_beat);
    pace();
    for (n = 0; n < 256; n++) begin
      calm = (n < 128);
      send_cmd(CMD_TICK, HANDLE_W'($urandom), $urandom, $urandom, SLOT_W'($urandom),
               1'b0, idle_beat);
      pace();
    end
    calm = 1'b0;
    repeat (2) begin
      send_cmd(CMD_DISPATCH, HANDLE_W'($urandom), $urandom, $urandom, SLOT_W'($urandom),
               1'b0, idle_beat);
      pace();
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb_tick_task_scheduler: clean");
    end else begin
      $display("tb_tick_task_scheduler: errors");
    end
    $finish;
  end

endmodule
